FILE: design/nccb_pkg.sv
// Shared types and fixed-point constants for the normal CDF confidence bound block.
// Used by nccb_coef_rom, nccb_horner_cell and normal_cdf_confidence_bound.
`default_nettype none

package nccb_pkg;

   // Width of one stored polynomial coefficient (signed Q30).
   localparam int COEF_W = 34;
   // Width of the Horner accumulator (signed Q30 with headroom).
   localparam int ACC_W = 36;
   // Width of the fractional position inside one segment (Q18).
   localparam int FRAC_W = 18;

   localparam int BETA_W = 16;
   localparam int ACTION_W = 2;
   localparam int MEAN_W = 21;
   localparam int SD_W = 20;
   localparam int PROB_W = 16;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_CLASS = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOWER = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_UPPER = 2'd2;

   localparam logic [BETA_W-1:0] BETA_RESET = 16'd8192;

   // 1/sqrt(2) in Q30.
   localparam logic [29:0] RSQRT2_Q30 = 30'd759250125;

   // Payload handed from one Horner cell to the next. coefs[2] is the next
   // coefficient to add; the vector shifts up by one position per cell.
   typedef struct packed {
      logic signed [ACC_W-1:0]   acc;
      logic [2:0][COEF_W-1:0]    coefs;
      logic [FRAC_W-1:0]         frac;
      logic                      sat;
      logic                      neg;
   } cell_data_type;

endpackage

`default_nettype wire

FILE: design/nccb_coef_rom.sv
// Constant table of cubic erf segments, built at elaboration in integer arithmetic.
// Depends on nccb_pkg for the coefficient width.
`default_nettype none

module nccb_coef_rom #(
   parameter int ERF_SEGMENTS = 32
) (
   input  wire logic [$clog2(ERF_SEGMENTS)-1:0]           index,
   output logic      [3:0][nccb_pkg::COEF_W-1:0]          coefs
);

   localparam int IDX_W = $clog2(ERF_SEGMENTS);
   localparam int ROM_DEPTH = 2 ** IDX_W;
   localparam int SIMPSON_N = 16;
   localparam longint unsigned Q30_ONE = 64'd1073741824;
   localparam longint unsigned LN2_Q30 = 64'd744261118;
   localparam longint unsigned TWO_RSQRTPI_Q30 = 64'd1211587905;
   localparam longint unsigned GAUSS_DEN = 64'(16 * ERF_SEGMENTS * ERF_SEGMENTS);
   localparam longint unsigned GAUSS_HALF = 64'(8 * ERF_SEGMENTS * ERF_SEGMENTS);
   localparam longint SEG_COUNT = longint'(ERF_SEGMENTS);
   localparam longint SEG_HALF = longint'(ERF_SEGMENTS / 2);
   localparam longint SIMPSON_DEN = longint'(12 * ERF_SEGMENTS);
   localparam longint SIMPSON_BIAS = longint'(6 * ERF_SEGMENTS);

   // Quotient by a small count, worked out bit by bit at elaboration. The dividend
   // always fits in 32 bits here.
   function automatic longint unsigned div_small(input longint unsigned num,
                                                 input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int b = 31; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-u) for u in Q30: range reduction by ln2, then a truncating series.
   function automatic longint unsigned exp_neg(input longint unsigned u);
      longint unsigned k;
      longint unsigned r;
      longint unsigned term;
      longint acc;
      k = u / LN2_Q30;
      r = u - k * LN2_Q30;
      term = Q30_ONE;
      acc = longint'(Q30_ONE);
      for (int n = 1; n <= 24; n++) begin
         if (term != 0) begin
            term = div_small((term * r) >> 30, 64'(n));
            if (n[0]) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (k >= 40) begin
         return 64'd0;
      end
      return longint'(acc) >> k;
   endfunction

   // 2/sqrt(pi) * exp(-t^2) at t = n / (4 * ERF_SEGMENTS), in Q30.
   function automatic longint gauss(input longint unsigned n);
      longint unsigned u;
      longint unsigned e;
      u = ((n * n) << 30) + GAUSS_HALF;
      u = u / GAUSS_DEN;
      e = exp_neg(u);
      return longint'((e * TWO_RSQRTPI_Q30 + (64'd1 << 29)) >> 30);
   endfunction

   // Slope at knot m, scaled by the segment width.
   function automatic longint knot_slope(input int m);
      longint d;
      d = gauss(64'(m * SIMPSON_N));
      return (4 * d + SEG_HALF) / SEG_COUNT;
   endfunction

   // Cubic Hermite coefficients {c3, c2, c1, c0} of segment k.
   function automatic logic [3:0][nccb_pkg::COEF_W-1:0] seg_coef(input int k);
      longint y_lo;
      longint y_hi;
      longint sum;
      longint wgt;
      longint p;
      longint q;
      logic [3:0][nccb_pkg::COEF_W-1:0] c;
      y_lo = 0;
      y_hi = 0;
      for (int m = 1; m <= k + 1; m++) begin
         sum = 0;
         for (int j = 0; j <= SIMPSON_N; j++) begin
            if (j == 0 || j == SIMPSON_N) begin
               wgt = 1;
            end else if (j[0]) begin
               wgt = 4;
            end else begin
               wgt = 2;
            end
            sum = sum + wgt * gauss(64'((m - 1) * SIMPSON_N + j));
         end
         y_lo = y_hi;
         y_hi = y_hi + (sum + SIMPSON_BIAS) / SIMPSON_DEN;
      end
      p = knot_slope(k);
      q = knot_slope(k + 1);
      c[0] = y_lo[nccb_pkg::COEF_W-1:0];
      c[1] = p[nccb_pkg::COEF_W-1:0];
      c[2] = nccb_pkg::COEF_W'(3 * (y_hi - y_lo) - 2 * p - q);
      c[3] = nccb_pkg::COEF_W'(2 * (y_lo - y_hi) + p + q);
      return c;
   endfunction

   logic [3:0][nccb_pkg::COEF_W-1:0] rom [ROM_DEPTH];

   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_seg
      if (g < ERF_SEGMENTS) begin : g_used
         localparam logic [3:0][nccb_pkg::COEF_W-1:0] SEG_C = seg_coef(g);
         assign rom[g] = SEG_C;
      end else begin : g_pad
         assign rom[g] = '0;
      end
   end

   assign coefs = rom[index];

endmodule

`default_nettype wire

FILE: design/nccb_horner_cell.sv
// One Horner step cell: acc <- next coefficient + (acc * frac) / 2^18, toward zero.
// Depends on nccb_pkg for the cell payload type.
`default_nettype none

module nccb_horner_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire nccb_pkg::cell_data_type in_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output nccb_pkg::cell_data_type      out_data
);

   localparam int PROD_W = nccb_pkg::ACC_W + nccb_pkg::FRAC_W + 1;

   logic                           valid_ff;
   nccb_pkg::cell_data_type        data_ff;
   nccb_pkg::cell_data_type        data_in;
   logic signed [PROD_W-1:0]       prod;
   logic signed [PROD_W-1:0]       biased;
   logic signed [PROD_W-1:0]       quot;
   logic signed [nccb_pkg::ACC_W-1:0] coef_ext;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      prod = PROD_W'(in_data.acc) * $signed({1'b0, in_data.frac});
      // Bias negative products so the arithmetic shift truncates toward zero.
      biased = prod[PROD_W-1] ? (prod + PROD_W'((1 << nccb_pkg::FRAC_W) - 1)) : prod;
      quot = biased >>> nccb_pkg::FRAC_W;
      coef_ext = nccb_pkg::ACC_W'($signed(in_data.coefs[2]));
      data_in = in_data;
      data_in.acc = coef_ext + quot[nccb_pkg::ACC_W-1:0];
      data_in.coefs = {in_data.coefs[1], in_data.coefs[0], {nccb_pkg::COEF_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

`default_nettype wire

FILE: design/normal_cdf_confidence_bound.sv
// A result reaches rsp_valid through stages 1 to 4, the Horner cells and the output register.
// Throughput: one item per cycle while rsp_ready is high; every stage has its own valid bit and moves up
// as soon as the stage after it is empty or moving, so bubbles close up under stall.
// Reset (synchronous, active high) empties all stages and sets beta to 2.0 (Q4.12).
// Top level; depends on nccb_pkg, nccb_coef_rom and nccb_horner_cell.
`default_nettype none

module normal_cdf_confidence_bound #(
   parameter int ERF_SEGMENTS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [nccb_pkg::BETA_W-1:0]      csr_write_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [nccb_pkg::ACTION_W-1:0]    req_action,
   input  wire logic signed [nccb_pkg::MEAN_W-1:0] req_mean_value,
   input  wire logic [nccb_pkg::SD_W-1:0]        req_std_dev,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [nccb_pkg::PROB_W-1:0]           rsp_probability
);

   localparam int IDX_W = $clog2(ERF_SEGMENTS);
   localparam int V_W = nccb_pkg::FRAC_W + $clog2(ERF_SEGMENTS + 1);
   localparam int BW_W = 25;
   localparam int X_W = 27;
   localparam int T_W = 20;
   localparam int CELLS = 3;
   localparam logic [30:0] E_ONE = 31'h4000_0000;

   // The beta register is written directly; there is no read-back.
   logic [nccb_pkg::BETA_W-1:0] beta_ff;
   logic [nccb_pkg::BETA_W-1:0] beta_in;

   assign beta_in = csr_write_enable ? csr_write_data : beta_ff;

   // Stage 1: capture the transfer and form beta * sd, rounded half up to Q9.16.
   logic                              s1_valid_ff;
   logic                              s1_ready;
   logic [nccb_pkg::ACTION_W-1:0]     s1_action_ff;
   logic signed [nccb_pkg::MEAN_W-1:0] s1_mean_ff;
   logic [BW_W-1:0]                   s1_bw_ff;
   logic [BW_W-1:0]                   s1_bw_in;
   logic [nccb_pkg::BETA_W+nccb_pkg::SD_W:0] bw_prod;

   // Stage 2: saturated argument split into sign and magnitude.
   logic                              s2_valid_ff;
   logic                              s2_ready;
   logic                              s2_neg_ff;
   logic [nccb_pkg::MEAN_W-1:0]       s2_mag_ff;
   logic signed [X_W-1:0]             x_raw;
   logic signed [X_W-1:0]             x_sat;
   logic                              s2_neg_in;
   logic [nccb_pkg::MEAN_W-1:0]       s2_mag_in;

   // Stage 3: t = |x| / sqrt(2) in Q16.
   logic                              s3_valid_ff;
   logic                              s3_ready;
   logic                              s3_neg_ff;
   logic [T_W-1:0]                    s3_t_ff;
   logic [nccb_pkg::MEAN_W+30:0]      t_prod;

   // Stage 4: segment lookup; loads the first Horner cell's payload.
   logic                              s4_valid_ff;
   logic                              s4_ready;
   nccb_pkg::cell_data_type           s4_data_ff;
   nccb_pkg::cell_data_type           s4_data_in;
   logic [V_W-1:0]                    seg_pos;
   logic [IDX_W-1:0]                  seg_index;
   logic [3:0][nccb_pkg::COEF_W-1:0]  seg_coefs;

   // Horner chain.
   logic                              cell_valid [CELLS+1];
   logic                              cell_ready [CELLS+1];
   nccb_pkg::cell_data_type           cell_data  [CELLS+1];

   // Output register: clamp erf, fold in the sign and round to Q0.16.
   logic                              rsp_valid_ff;
   logic [nccb_pkg::PROB_W-1:0]       rsp_probability_ff;
   logic [nccb_pkg::PROB_W-1:0]       rsp_probability_in;
   logic                              out_ready;
   nccb_pkg::cell_data_type           fin;
   logic [30:0]                       erf_q30;
   logic [30:0]                       p_q30;
   logic [31:0]                       p_round;

   // Each stage takes new data when it is empty or its content is leaving.
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign cell_ready[CELLS] = out_ready;
   assign s4_ready = !s4_valid_ff || cell_ready[0];
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_comb begin
      bw_prod = (nccb_pkg::BETA_W + nccb_pkg::SD_W + 1)'(beta_ff * req_std_dev)
                + (nccb_pkg::BETA_W + nccb_pkg::SD_W + 1)'(2048);
      s1_bw_in = bw_prod[12 +: BW_W];
   end

   // The argument: mean alone, mean - beta*sd or mean + beta*sd. The unused
   // action code behaves as a class probability request.
   always_comb begin
      case (s1_action_ff)
         nccb_pkg::ACT_LOWER: x_raw = X_W'(s1_mean_ff) - X_W'($signed({1'b0, s1_bw_ff}));
         nccb_pkg::ACT_UPPER: x_raw = X_W'(s1_mean_ff) + X_W'($signed({1'b0, s1_bw_ff}));
         default:             x_raw = X_W'(s1_mean_ff);
      endcase
      if (x_raw > X_W'(1048575)) begin
         x_sat = X_W'(1048575);
      end else if (x_raw < -X_W'(1048576)) begin
         x_sat = -X_W'(1048576);
      end else begin
         x_sat = x_raw;
      end
      s2_neg_in = x_sat[X_W-1];
      s2_mag_in = s2_neg_in ? nccb_pkg::MEAN_W'(-x_sat) : nccb_pkg::MEAN_W'(x_sat);
   end

   assign t_prod = (nccb_pkg::MEAN_W + 31)'(s2_mag_ff * nccb_pkg::RSQRT2_Q30)
                   + (nccb_pkg::MEAN_W + 31)'(64'd1 << 29);

   // Segment index and position within it; at t >= 4 erf is taken as one.
   always_comb begin
      seg_pos = V_W'(s3_t_ff[nccb_pkg::FRAC_W-1:0]) * V_W'(ERF_SEGMENTS);
      seg_index = seg_pos[nccb_pkg::FRAC_W +: IDX_W];
      s4_data_in.sat = |s3_t_ff[T_W-1:nccb_pkg::FRAC_W];
      s4_data_in.neg = s3_neg_ff;
      s4_data_in.frac = seg_pos[nccb_pkg::FRAC_W-1:0];
      s4_data_in.acc = nccb_pkg::ACC_W'($signed(seg_coefs[3]));
      s4_data_in.coefs = {seg_coefs[2], seg_coefs[1], seg_coefs[0]};
   end

   nccb_coef_rom #(
      .ERF_SEGMENTS (ERF_SEGMENTS)
   ) u_coef_rom (
      .index (seg_index),
      .coefs (seg_coefs)
   );

   assign cell_valid[0] = s4_valid_ff;
   assign cell_data[0] = s4_data_ff;

   for (genvar c = 0; c < CELLS; c++) begin : g_cell
      nccb_horner_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[c]),
         .in_ready  (cell_ready[c]),
         .in_data   (cell_data[c]),
         .out_valid (cell_valid[c+1]),
         .out_ready (cell_ready[c+1]),
         .out_data  (cell_data[c+1])
      );
   end

   // Clamp erf to [0, 1], then P = 1/2 +/- erf/2 and round to 16 bits.
   always_comb begin
      fin = cell_data[CELLS];
      if (fin.sat) begin
         erf_q30 = E_ONE;
      end else if (fin.acc < 0) begin
         erf_q30 = '0;
      end else if (fin.acc > nccb_pkg::ACC_W'(E_ONE)) begin
         erf_q30 = E_ONE;
      end else begin
         erf_q30 = fin.acc[30:0];
      end
      if (fin.neg) begin
         p_q30 = 31'h2000_0000 - {1'b0, erf_q30[30:1]};
      end else begin
         p_q30 = 31'h2000_0000 + {1'b0, erf_q30[30:1]};
      end
      p_round = {1'b0, p_q30} + 32'd8192;
      rsp_probability_in = (|p_round[31:30]) ? '1 : p_round[29:14];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= nccb_pkg::BETA_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beta_ff <= beta_in;
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= cell_valid[CELLS];
         end
      end
      // Payload registers load on a transfer into the stage and need no reset.
      if (s1_ready && req_valid) begin
         s1_action_ff <= req_action;
         s1_mean_ff <= req_mean_value;
         s1_bw_ff <= s1_bw_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_neg_ff <= s2_neg_in;
         s2_mag_ff <= s2_mag_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_neg_ff <= s2_neg_ff;
         s3_t_ff <= t_prod[30 +: T_W];
      end
      if (s4_ready && s3_valid_ff) begin
         s4_data_ff <= s4_data_in;
      end
      if (out_ready && cell_valid[CELLS]) begin
         rsp_probability_ff <= rsp_probability_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_probability = rsp_probability_ff;

   // The input side only stalls when every stage holds an item.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff
                      && cell_valid[1] && cell_valid[2] && cell_valid[3] && rsp_valid_ff))
      else $error("input stalled while the pipeline has an empty stage");

   // A large argument must give a probability of exactly zero or one.
   assert property (@(posedge clock) disable iff (reset)
      (cell_valid[CELLS] && out_ready && fin.sat)
      |=> (rsp_probability == '0 || rsp_probability == '1))
      else $error("saturated argument did not give an extreme probability");

   // The sign of the argument decides which half of the range the result is in.
   assert property (@(posedge clock) disable iff (reset)
      (cell_valid[CELLS] && out_ready && fin.neg) |=> (rsp_probability <= 16'd32768))
      else $error("negative argument gave a probability above one half");

   assert property (@(posedge clock) disable iff (reset)
      (cell_valid[CELLS] && out_ready && !fin.neg) |=> (rsp_probability >= 16'd32768))
      else $error("non-negative argument gave a probability below one half");

endmodule

`default_nettype wire
